### rtl/core/assert_macros.svh
// assertion macros used by the grid longest increasing path rtl
// no dependencies; concurrent checks are left out of synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/gli_pkg.sv
// shared types and codes for the grid longest increasing path block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gli_pkg;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 5;
    localparam int IN_DATA_BITS   = 32;
    localparam int OUT_DATA_BITS  = 16;
    localparam int LEN_OUT_BITS   = 9;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COL_COUNT = 1'b1;

    localparam logic [2:0] DIR_N   = 3'd0;
    localparam logic [2:0] DIR_E   = 3'd1;
    localparam logic [2:0] DIR_S   = 3'd2;
    localparam logic [2:0] DIR_W   = 3'd3;
    localparam logic [2:0] DIR_END = 3'd4;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CLEAR    = 8'b0000_0010,
        ST_SCAN     = 8'b0000_0100,
        ST_SCAN_CHK = 8'b0000_1000,
        ST_STEP     = 8'b0001_0000,
        ST_CHECK    = 8'b0010_0000,
        ST_POP      = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;
endpackage
`default_nettype wire

### rtl/core/gli_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module gli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/grid_longest_increasing_path.sv
// channel | ports                          | payload
// input   | s_tvalid s_tready s_tdata[31:0] | cell_value
// result  | m_tvalid m_tready m_tdata[15:0] | path_length in [8:0]
// config  | cfg_valid cfg_ready cfg_index   | cfg_data[4:0] = row_count / col_count
// loading takes one cell per accepted beat; the last cell starts the solve.
// solve: a clear sweep over all rows*cols cells, a scan and check per start
// cell, then per searched cell a step per off-grid direction, a step and check
// per neighbor read, a step to finish it and a pop; the done state moves the
// result out. the grid, length and stack memories have one read port each.
// no input is taken while solving; the result waits in an output register.
// reset is synchronous; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grid_longest_increasing_path #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [gli_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [31:0] cell_value
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [gli_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // [8:0] path_length
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gli_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [gli_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import gli_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CWD   = $clog2(MAX_COLS + 1);
    localparam int EXT   = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    typedef struct packed {
        logic [VALUE_BITS-1:0] val;
        logic [CW-1:0]         m;
        logic [2:0]            dir;
        logic [CWD-1:0]        c;
        logic [RW-1:0]         r;
        logic [AW-1:0]         idx;
    } frame_t;
    localparam int FW = $bits(frame_t);

    state_t state_reg, state_next;
    logic [CFG_DATA_BITS-1:0] row_count_reg, col_count_reg;
    logic [CW-1:0]  load_cnt_reg, load_cnt_next;
    logic [CW-1:0]  s_idx_reg, s_idx_next;
    logic [RW-1:0]  s_r_reg, s_r_next;
    logic [CWD-1:0] s_c_reg, s_c_next;
    frame_t         cur_reg, cur_next;
    logic [CW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  best_reg, best_next;
    logic [CW-1:0]  fin_len_reg, fin_len_next;
    logic           out_valid_reg;
    logic [LEN_OUT_BITS-1:0] out_len_reg;

    logic [RW-1:0]  rows_cl;
    logic [CWD-1:0] cols_cl;
    logic [CW-1:0]  total;
    logic           s_fire, done_load;
    logic [EXT-1:0] in_ext;

    logic           n_ok;
    logic [AW-1:0]  n_idx;
    logic [RW-1:0]  n_r;
    logic [CWD-1:0] n_c;

    logic                  grid_we;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] grid_rdata;
    logic                  len_we;
    logic [AW-1:0]         len_waddr;
    logic [CW-1:0]         len_wdata, len_rdata;
    logic                  stk_we;
    frame_t                stk_wdata, stk_rdata;
    logic [CW-1:0]         cur_len;

    // dimensions: zero reads as one, oversize saturates
    always_comb begin
        if (row_count_reg == '0) begin
            rows_cl = RW'(1);
        end else if (32'(row_count_reg) > MAX_ROWS) begin
            rows_cl = RW'(MAX_ROWS);
        end else begin
            rows_cl = RW'(row_count_reg);
        end
        if (col_count_reg == '0) begin
            cols_cl = CWD'(1);
        end else if (32'(col_count_reg) > MAX_COLS) begin
            cols_cl = CWD'(MAX_COLS);
        end else begin
            cols_cl = CWD'(col_count_reg);
        end
    end
    assign total = CW'(CW'(rows_cl) * CW'(cols_cl));

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CFG_DATA_BITS'(16);
            col_count_reg <= CFG_DATA_BITS'(16);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                CFG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_ext    = EXT'(s_tdata);
    assign grid_we   = s_fire && (32'(load_cnt_reg) < CELLS);
    assign done_load = (load_cnt_reg + CW'(1)) >= total;

    // neighbor of the frame on top
    always_comb begin
        n_ok  = 1'b0;
        n_idx = cur_reg.idx;
        n_r   = cur_reg.r;
        n_c   = cur_reg.c;
        case (cur_reg.dir)
            DIR_N: begin
                n_ok  = (cur_reg.r != '0);
                n_idx = cur_reg.idx - AW'(cols_cl);
                n_r   = cur_reg.r - RW'(1);
            end
            DIR_E: begin
                n_ok  = ((CWD+1)'(cur_reg.c) + (CWD+1)'(1)) < (CWD+1)'(cols_cl);
                n_idx = cur_reg.idx + AW'(1);
                n_c   = cur_reg.c + CWD'(1);
            end
            DIR_S: begin
                n_ok  = ((RW+1)'(cur_reg.r) + (RW+1)'(1)) < (RW+1)'(rows_cl);
                n_idx = cur_reg.idx + AW'(cols_cl);
                n_r   = cur_reg.r + RW'(1);
            end
            DIR_W: begin
                n_ok  = (cur_reg.c != '0);
                n_idx = cur_reg.idx - AW'(1);
                n_c   = cur_reg.c - CWD'(1);
            end
            default: ;
        endcase
    end

    assign cur_len   = cur_reg.m + CW'(1);
    assign rd_addr   = (state_reg == ST_SCAN) ? s_idx_reg[AW-1:0] : n_idx;
    assign len_we    = (state_reg == ST_CLEAR) ||
                       ((state_reg == ST_STEP) && (cur_reg.dir == DIR_END));
    assign len_waddr = (state_reg == ST_CLEAR) ? s_idx_reg[AW-1:0] : cur_reg.idx;
    assign len_wdata = (state_reg == ST_CLEAR) ? '0 : cur_len;

    always_comb begin
        stk_wdata     = cur_reg;
        stk_wdata.dir = cur_reg.dir + 3'd1;
    end
    assign stk_we = (state_reg == ST_CHECK) &&
                    ($signed(grid_rdata) > $signed(cur_reg.val)) && (len_rdata == '0);

    gli_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_grid_ram (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata (in_ext[VALUE_BITS-1:0]),
        .raddr (rd_addr),
        .rdata (grid_rdata)
    );

    gli_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (rd_addr),
        .rdata (len_rdata)
    );

    gli_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (depth_reg[AW-1:0]),
        .wdata (stk_wdata),
        .raddr (AW'(depth_reg - CW'(1))),
        .rdata (stk_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        s_idx_next    = s_idx_reg;
        s_r_next      = s_r_reg;
        s_c_next      = s_c_reg;
        cur_next      = cur_reg;
        depth_next    = depth_reg;
        best_next     = best_reg;
        fin_len_next  = fin_len_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (done_load) begin
                        load_cnt_next = '0;
                        s_idx_next    = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                end
            end
            ST_CLEAR: begin
                if (s_idx_reg + CW'(1) >= total) begin
                    s_idx_next = '0;
                    s_r_next   = '0;
                    s_c_next   = '0;
                    best_next  = '0;
                    state_next = ST_SCAN;
                end else begin
                    s_idx_next = s_idx_reg + CW'(1);
                end
            end
            ST_SCAN: begin
                state_next = (s_idx_reg >= total) ? ST_DONE : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (len_rdata != '0) begin
                    if (len_rdata > best_reg) begin
                        best_next = len_rdata;
                    end
                    s_idx_next = s_idx_reg + CW'(1);
                    if (s_c_reg == cols_cl - CWD'(1)) begin
                        s_c_next = '0;
                        s_r_next = s_r_reg + RW'(1);
                    end else begin
                        s_c_next = s_c_reg + CWD'(1);
                    end
                    state_next = ST_SCAN;
                end else begin
                    cur_next.idx = s_idx_reg[AW-1:0];
                    cur_next.r   = s_r_reg;
                    cur_next.c   = s_c_reg;
                    cur_next.dir = DIR_N;
                    cur_next.m   = '0;
                    cur_next.val = grid_rdata;
                    depth_next   = '0;
                    state_next   = ST_STEP;
                end
            end
            ST_STEP: begin
                if (cur_reg.dir == DIR_END) begin
                    fin_len_next = cur_len;
                    if (depth_reg == '0) begin
                        // root finished, its length is final for this start
                        if (cur_len > best_reg) begin
                            best_next = cur_len;
                        end
                        s_idx_next = s_idx_reg + CW'(1);
                        if (s_c_reg == cols_cl - CWD'(1)) begin
                            s_c_next = '0;
                            s_r_next = s_r_reg + RW'(1);
                        end else begin
                            s_c_next = s_c_reg + CWD'(1);
                        end
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_POP;
                    end
                end else if (n_ok) begin
                    state_next = ST_CHECK;
                end else begin
                    cur_next.dir = cur_reg.dir + 3'd1;
                end
            end
            ST_CHECK: begin
                state_next = ST_STEP;
                if ($signed(grid_rdata) > $signed(cur_reg.val)) begin
                    if (len_rdata == '0) begin
                        cur_next.idx = n_idx;
                        cur_next.r   = n_r;
                        cur_next.c   = n_c;
                        cur_next.dir = DIR_N;
                        cur_next.m   = '0;
                        cur_next.val = grid_rdata;
                        depth_next   = depth_reg + CW'(1);
                    end else begin
                        if (len_rdata > cur_reg.m) begin
                            cur_next.m = len_rdata;
                        end
                        cur_next.dir = cur_reg.dir + 3'd1;
                    end
                end else begin
                    cur_next.dir = cur_reg.dir + 3'd1;
                end
            end
            ST_POP: begin
                cur_next = stk_rdata;
                if (fin_len_reg > stk_rdata.m) begin
                    cur_next.m = fin_len_reg;
                end
                depth_next = depth_reg - CW'(1);
                state_next = ST_STEP;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            load_cnt_reg  <= '0;
            best_reg      <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            best_reg     <= best_next;
            depth_reg    <= depth_next;
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s_idx_reg   <= s_idx_next;
        s_r_reg     <= s_r_next;
        s_c_reg     <= s_c_next;
        cur_reg     <= cur_next;
        fin_len_reg <= fin_len_next;
        if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
            out_len_reg <= (32'(best_reg) > 32'd511) ? 9'h1FF : 9'(best_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-LEN_OUT_BITS){1'b0}}, out_len_reg};

    `ASSERT_CLK(a_stack_bound, aclk, aresetn, 32'(depth_reg) < CELLS, "stack depth out of range")
    `ASSERT_CLK(a_last_cell_solves, aclk, aresetn, (s_fire && done_load) |=> (state_reg == ST_CLEAR), "last cell did not start solve")
    `ASSERT_NEVER(a_push_overflow, aclk, aresetn, stk_we && (32'(depth_reg) + 1 >= CELLS), "push beyond stack")
    `ASSERT_CLK(a_load_in_range, aclk, aresetn, (state_reg == ST_IDLE) |-> (32'(load_cnt_reg) < CELLS), "load count beyond grid")
endmodule
`default_nettype wire
